>>> rtl/som_pkg.sv
package som_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned RING_W  = 2;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_READ = 3'b010,
    ST_SHOW = 3'b100
  } state_e;

  typedef enum logic [1:0] {
    DIR_TOP    = 2'd0,
    DIR_RIGHT  = 2'd1,
    DIR_BOTTOM = 2'd2,
    DIR_LEFT   = 2'd3
  } dir_e;

  typedef struct packed {
    logic load;     // write incoming word, bump load count
    logic start;    // reset spiral walker
    logic read;     // read store at walker position into output register
    logic advance;  // step walker to next position
  } cmd_t;

  typedef struct packed {
    logic load_last;  // current load fills the matrix
    logic out_last;   // word in output register ends the spiral
  } status_t;

endpackage

>>> rtl/som_ctrl.sv
module som_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  som_pkg::status_t status_i,
  output som_pkg::cmd_t    cmd_o
);

  som_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= som_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      som_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.load_last) begin
            cmd_o.start = 1'b1;
            state_d     = som_pkg::ST_READ;
          end
        end
      end
      som_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = som_pkg::ST_SHOW;
      end
      som_pkg::ST_SHOW: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = som_pkg::ST_LOAD;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = som_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_d = som_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/som_datapath.sv
module som_datapath #(
  parameter int unsigned MAX_SIDE = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [som_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic signed [som_pkg::VALUE_W-1:0]  element_value_i,
  input  som_pkg::cmd_t                       cmd_i,
  output som_pkg::status_t                    status_o,
  output logic signed [som_pkg::VALUE_W-1:0]  value_o,
  output logic [som_pkg::IDX_W-1:0]           row_o,
  output logic [som_pkg::IDX_W-1:0]           col_o,
  output logic                                last_o
);

  localparam int unsigned DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW    = som_pkg::IDX_W + som_pkg::SIZE_W;

  logic [som_pkg::VALUE_W-1:0] mem [DEPTH];

  logic [som_pkg::SIZE_W-1:0] side_q, side_d;
  logic [AW-1:0]              load_cnt_q, load_cnt_d;
  logic [AW-1:0]              emit_cnt_q, emit_cnt_d;
  logic [som_pkg::RING_W-1:0] ring_q, ring_d;
  logic [som_pkg::IDX_W-1:0]  row_q, row_d;
  logic [som_pkg::IDX_W-1:0]  col_q, col_d;
  som_pkg::dir_e              dir_q, dir_d;

  logic [som_pkg::VALUE_W-1:0] value_q;
  logic [som_pkg::IDX_W-1:0]   row_out_q;
  logic [som_pkg::IDX_W-1:0]   col_out_q;
  logic                        last_q;

  logic [2*som_pkg::SIZE_W-1:0] total_w;
  logic [AW-1:0]                total_m1;
  logic [LW-1:0]                lin;
  logic [AW-1:0]                rd_addr;
  logic [som_pkg::IDX_W-1:0]    end_w, end_m1, ring_p1;
  logic [som_pkg::SIZE_W-1:0]   side_clamped;

  assign total_w  = side_q * side_q;
  assign total_m1 = AW'(total_w - 1'b1);
  assign lin      = LW'(row_q) * LW'(side_q) + LW'(col_q);
  assign rd_addr  = lin[AW-1:0];
  assign end_w    = som_pkg::IDX_W'(side_q - 1'b1) - som_pkg::IDX_W'(ring_q);
  assign end_m1   = end_w - 1'b1;
  assign ring_p1  = som_pkg::IDX_W'(ring_q) + 1'b1;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      side_clamped = som_pkg::SIZE_W'(1);
    end else if (cfg_wdata_i > som_pkg::SIZE_W'(MAX_SIDE)) begin
      side_clamped = som_pkg::SIZE_W'(MAX_SIDE);
    end else begin
      side_clamped = cfg_wdata_i;
    end
  end

  always_comb begin
    side_d     = side_q;
    load_cnt_d = load_cnt_q;
    if (cfg_we_i) begin
      side_d     = side_clamped;
      load_cnt_d = '0;
    end else if (cmd_i.load) begin
      load_cnt_d = (load_cnt_q == total_m1) ? '0 : load_cnt_q + 1'b1;
    end
  end

  // spiral walker: the left run stops one short of its ring's start
  always_comb begin
    ring_d     = ring_q;
    row_d      = row_q;
    col_d      = col_q;
    dir_d      = dir_q;
    emit_cnt_d = emit_cnt_q;
    if (cmd_i.start) begin
      ring_d     = '0;
      row_d      = '0;
      col_d      = '0;
      dir_d      = som_pkg::DIR_TOP;
      emit_cnt_d = '0;
    end else if (cmd_i.advance) begin
      emit_cnt_d = emit_cnt_q + 1'b1;
      case (dir_q)
        som_pkg::DIR_TOP: begin
          if (col_q == end_m1) dir_d = som_pkg::DIR_RIGHT;
          col_d = col_q + 1'b1;
        end
        som_pkg::DIR_RIGHT: begin
          if (row_q == end_m1) dir_d = som_pkg::DIR_BOTTOM;
          row_d = row_q + 1'b1;
        end
        som_pkg::DIR_BOTTOM: begin
          if (col_q == ring_p1) dir_d = som_pkg::DIR_LEFT;
          col_d = col_q - 1'b1;
        end
        som_pkg::DIR_LEFT: begin
          if (row_q == ring_p1) begin
            ring_d = ring_q + 1'b1;
            row_d  = ring_p1;
            col_d  = ring_p1;
            dir_d  = som_pkg::DIR_TOP;
          end else begin
            row_d = row_q - 1'b1;
          end
        end
        default: begin
          dir_d = som_pkg::DIR_TOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q     <= som_pkg::SIZE_W'(MAX_SIDE);
      load_cnt_q <= '0;
      emit_cnt_q <= '0;
      ring_q     <= '0;
      row_q      <= '0;
      col_q      <= '0;
      dir_q      <= som_pkg::DIR_TOP;
      last_q     <= 1'b0;
    end else begin
      side_q     <= side_d;
      load_cnt_q <= load_cnt_d;
      emit_cnt_q <= emit_cnt_d;
      ring_q     <= ring_d;
      row_q      <= row_d;
      col_q      <= col_d;
      dir_q      <= dir_d;
      if (cmd_i.read) begin
        last_q <= (emit_cnt_q == total_m1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mem[load_cnt_q] <= element_value_i;
    end
    if (cmd_i.read) begin
      value_q   <= mem[rd_addr];
      row_out_q <= row_q;
      col_out_q <= col_q;
    end
  end

  assign status_o.load_last = (load_cnt_q == total_m1);
  assign status_o.out_last  = last_q;

  assign value_o = value_q;
  assign row_o   = row_out_q;
  assign col_o   = col_out_q;
  assign last_o  = last_q;

endmodule

>>> rtl/spiral_order_matrix_scan.sv
// Collects an N by N matrix of signed 32-bit words in row-major order, one word
// per cycle while in_ready_o is high, and after the word at index N*N-1 plays
// all N*N words back in clockwise spiral order with row, column and a last
// flag on the final word. N comes from cfg_wdata_i (0 reads as 1, values above
// MAX_SIDE as MAX_SIDE); a write restarts the load. Playback reads each word
// through the single read port of the matrix store into the output register,
// then holds it there until out_ready_i takes it; no input is taken during
// playback.
module spiral_order_matrix_scan #(
  parameter int unsigned MAX_SIDE = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [som_pkg::SIZE_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [som_pkg::VALUE_W-1:0]  element_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [som_pkg::VALUE_W-1:0]  value_o,
  output logic [som_pkg::IDX_W-1:0]           row_o,
  output logic [som_pkg::IDX_W-1:0]           col_o,
  output logic                                last_o
);

  som_pkg::cmd_t    cmd;
  som_pkg::status_t status;

  som_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  som_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .element_value_i (element_value_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .value_o         (value_o),
    .row_o           (row_o),
    .col_o           (col_o),
    .last_o          (last_o)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("load and playback active together");

  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o |=> in_ready_o)
    else $error("no return to loading after last word");

  a_next_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !out_valid_o && !in_ready_o)
    else $error("playback did not continue after word");

  a_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !cfg_we_i && status.load_last |=> !in_ready_o)
    else $error("full matrix did not start playback");

endmodule
